>>> sv/ldr_pkg.sv
// Shared widths, register indexes and reset values for the LED dimmer ramp.
`timescale 1ns / 1ps
`default_nettype none

package ldr_pkg;

  localparam int LVL_W   = 14;  // channel level, millivolts
  localparam int TIME_W  = 32;  // millisecond clock
  localparam int PER_W   = 16;  // ramp period, milliseconds
  localparam int WANT_W  = 16;  // requested level on the input
  localparam int CFG_A_W = 2;   // configuration register index
  localparam int CFG_D_W = 16;  // configuration write data
  localparam int MOVE_W  = 2 * LVL_W;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_LEVEL_LIMIT = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_RAMP_STEP   = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_PERIOD_MS   = 2'd2;

  // Register reset values
  localparam logic [LVL_W-1:0] LEVEL_LIMIT_RST = 14'd10000;
  localparam logic [LVL_W-1:0] RAMP_STEP_RST   = 14'd100;
  localparam logic [PER_W-1:0] PERIOD_MS_RST   = 16'd10;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } ldr_div_stat_t;

endpackage

`default_nettype wire

>>> sv/ldr_div.sv
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module ldr_div
  import ldr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [PER_W-1:0]  divisor,
  output ldr_div_stat_t          stat,
  output logic [TIME_W-1:0]      quot,
  output logic [PER_W-1:0]       rem
);

  localparam int CNT_W = $clog2(TIME_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] dvd_r, dvd_nxt;   // dividend shifts out, quotient shifts in
  logic [PER_W-1:0]  rem_r, rem_nxt;
  logic [PER_W-1:0]  div_r, div_nxt;
  logic [PER_W:0]    rem_sh;
  logic [PER_W:0]    rem_sub;
  logic              q_bit;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[TIME_W-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    q_bit   = (rem_sh >= {1'b0, div_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[TIME_W-2:0], q_bit};
      rem_nxt = q_bit ? rem_sub[PER_W-1:0] : rem_sh[PER_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = dvd_r;
  assign rem       = rem_r;

  // Done pulses exactly as the shift run ends
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished run");

  // Partial remainder always below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < div_r))
    else $error("divider remainder out of range");

  // Divisor must be nonzero when a run starts
  a_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> (div_r != '0))
    else $error("divider started with zero divisor");

endmodule

`default_nettype wire

>>> sv/dual_channel_led_dimmer_ramp.sv
// Top level of the two-channel LED dimmer ramp with relay.
`timescale 1ns / 1ps
`default_nettype none

// Two-channel LED dimmer ramp with relay. Each input item carries a
// millisecond timestamp, wanted levels for two channels and a wanted relay
// state, and gives exactly one result item. Wanted levels are clamped to
// level_limit; each channel then steps toward its target by ramp_step for
// every whole period_ms elapsed since the last run, snapping to the target
// when less than one step away and never passing it. The relay follows its
// request at once. The leftover part of a period carries to the next item.
// A period_ms of zero counts as one. An item passes in order through the
// bit-serial divider (one quotient bit at a time) that splits the elapsed
// time into whole periods and a remainder, the hand-over of its result,
// the step multiply and the update, which waits while the output register
// holds an untaken result. One item is worked on at a time; a new item may
// be accepted while the previous result still waits in the output register.
// Configuration writes are always taken and are meant for idle periods only.

module dual_channel_led_dimmer_ramp
  import ldr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [TIME_W-1:0]  in_now_ms,
  input  wire logic [WANT_W-1:0]  in_want_ch0,
  input  wire logic [WANT_W-1:0]  in_want_ch1,
  input  wire logic               in_want_relay,
  // result items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [LVL_W-1:0]        out_level_ch0,
  output logic [LVL_W-1:0]        out_level_ch1,
  output logic                    out_relay_on,
  output logic                    out_ch0_changed,
  output logic                    out_ch1_changed,
  output logic                    out_relay_changed,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_A_W-1:0] cfg_index,
  input  wire logic [CFG_D_W-1:0] cfg_value
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] ST_DIV  = 2'd1;  // serial division running
  localparam logic [1:0] ST_MUL  = 2'd2;  // periods times step
  localparam logic [1:0] ST_FIN  = 2'd3;  // update state, load result

  // Configuration registers
  logic [LVL_W-1:0]  level_limit_r;
  logic [LVL_W-1:0]  ramp_step_r;
  logic [PER_W-1:0]  period_ms_r;
  logic [PER_W-1:0]  per_eff;

  // Block state
  logic [1:0]        state_r, state_nxt;
  logic [TIME_W-1:0] last_run_r;
  logic [LVL_W-1:0]  ch0_level_r;
  logic [LVL_W-1:0]  ch1_level_r;
  logic              relay_r;

  // Item under way
  logic [TIME_W-1:0] now_r;
  logic [LVL_W-1:0]  tgt0_r, tgt1_r;
  logic              want_relay_r;
  logic [MOVE_W-1:0] move_r;
  logic              q_zero_r;   // less than one whole period elapsed
  logic              q_big_r;    // move certainly exceeds any level gap
  logic [PER_W-1:0]  rem_hold_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0]  out_l0_r, out_l1_r;
  logic              out_rel_r, out_c0_r, out_c1_r, out_cr_r;

  // Divider
  logic              in_acc;
  logic              div_start;
  logic [TIME_W-1:0] elapsed;
  ldr_div_stat_t     div_stat;
  logic [TIME_W-1:0] div_quot;
  logic [PER_W-1:0]  div_rem;

  logic              fin_go;
  logic [LVL_W-1:0]  n0, n1;
  logic [LVL_W-1:0]  tgt0_in, tgt1_in;

  // Clamp a wanted level to the limit
  function automatic logic [LVL_W-1:0] clamp_lvl(input logic [WANT_W-1:0] want,
                                                 input logic [LVL_W-1:0]  lim);
    logic [LVL_W-1:0] res;
    res = (want > WANT_W'(lim)) ? lim : want[LVL_W-1:0];
    return res;
  endfunction

  // One channel step toward its target, never past it
  function automatic logic [LVL_W-1:0] ramp_next(input logic [LVL_W-1:0]  cur,
                                                 input logic [LVL_W-1:0]  tgt,
                                                 input logic [LVL_W-1:0]  step,
                                                 input logic [MOVE_W-1:0] move,
                                                 input logic              q_zero,
                                                 input logic              q_big);
    logic [LVL_W-1:0] delta;
    logic [LVL_W-1:0] res;
    logic             up;
    up    = (cur < tgt);
    delta = up ? (tgt - cur) : (cur - tgt);
    priority if (cur == tgt || q_zero) begin
      res = cur;
    end else if (delta < step) begin
      res = tgt;
    end else if (q_big || move >= MOVE_W'(delta)) begin
      res = tgt;
    end else if (up) begin
      res = cur + move[LVL_W-1:0];
    end else begin
      res = cur - move[LVL_W-1:0];
    end
    return res;
  endfunction

  assign per_eff   = (period_ms_r == '0) ? PER_W'(1) : period_ms_r;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign div_start = in_acc;
  assign elapsed   = in_now_ms - last_run_r;
  assign cfg_ready = 1'b1;
  assign tgt0_in   = clamp_lvl(in_want_ch0, level_limit_r);
  assign tgt1_in   = clamp_lvl(in_want_ch1, level_limit_r);

  ldr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (per_eff),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Result may be loaded once the output register is free or being taken
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  assign n0 = ramp_next(ch0_level_r, tgt0_r, ramp_step_r, move_r, q_zero_r, q_big_r);
  assign n1 = ramp_next(ch1_level_r, tgt1_r, ramp_step_r, move_r, q_zero_r, q_big_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_DIV;
      ST_DIV:  if (div_stat.done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      level_limit_r <= LEVEL_LIMIT_RST;
      ramp_step_r   <= RAMP_STEP_RST;
      period_ms_r   <= PERIOD_MS_RST;
      last_run_r    <= '0;
      ch0_level_r   <= '0;
      ch1_level_r   <= '0;
      relay_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LEVEL_LIMIT: level_limit_r <= cfg_value[LVL_W-1:0];
          CFG_RAMP_STEP:   ramp_step_r   <= cfg_value[LVL_W-1:0];
          CFG_PERIOD_MS:   period_ms_r   <= cfg_value[PER_W-1:0];
          default: ;  // unused index, write dropped
        endcase
      end
      if (fin_go) begin
        ch0_level_r <= n0;
        ch1_level_r <= n1;
        relay_r     <= want_relay_r;
        last_run_r  <= now_r - TIME_W'(rem_hold_r);  // keep partial period
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r        <= in_now_ms;
      tgt0_r       <= tgt0_in;
      tgt1_r       <= tgt1_in;
      want_relay_r <= in_want_relay;
    end
    if (state_r == ST_MUL) begin
      move_r     <= MOVE_W'(div_quot[LVL_W-1:0]) * MOVE_W'(ramp_step_r);
      q_zero_r   <= (div_quot == '0);
      // a zero step never moves, however many periods have passed
      q_big_r    <= (|div_quot[TIME_W-1:LVL_W]) && (ramp_step_r != '0);
      rem_hold_r <= div_rem;
    end
    if (fin_go) begin
      out_l0_r  <= n0;
      out_l1_r  <= n1;
      out_rel_r <= want_relay_r;
      out_c0_r  <= (n0 != ch0_level_r);
      out_c1_r  <= (n1 != ch1_level_r);
      out_cr_r  <= (want_relay_r != relay_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level_ch0     = out_l0_r;
  assign out_level_ch1     = out_l1_r;
  assign out_relay_on      = out_rel_r;
  assign out_ch0_changed   = out_c0_r;
  assign out_ch1_changed   = out_c1_r;
  assign out_relay_changed = out_cr_r;

  // Divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the division state");

  // Divider is never busy while an item may be accepted
  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_stat.busy)
    else $error("item accepted with divider still running");

  // A result only appears after the update step
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result raised without an update step");

  // A loaded result is not overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready) |=> (state_r == ST_FIN))
    else $error("result register overwritten");

endmodule

`default_nettype wire
